// ----- design/pdt_pkg.sv -----
// Types and constants shared by the periodic deadline timer files.
package pdt_pkg;

	localparam int AddrWidth = 5;
	localparam int DataWidth = 64;

	localparam logic [19:0] MicrosPerSecond = 20'd1000000;

	localparam logic [47:0] TicksPerPeriodReset = 48'd1000;
	localparam logic [31:0] PeriodUsReset = 32'd1000;
	localparam logic [15:0] TicksPerUsReset = 16'd1000;
	localparam logic [19:0] PhaseUsReset = 20'd1000000;

	typedef enum logic [1:0] {
		REG_TICKS_PER_PERIOD = 2'd0,
		REG_PERIOD_US = 2'd1,
		REG_TICKS_PER_US = 2'd2,
		REG_PHASE_US = 2'd3
	} reg_idx_t;

	typedef enum logic {
		OP_CYCLE = 1'b0,
		OP_RESTART = 1'b1
	} op_t;

	typedef struct packed {
		logic operation;
		logic [63:0] now_ticks;
		logic [7:0] rephase_value;
	} req_t;

	typedef struct packed {
		logic [63:0] deadline_ticks;
		logic [31:0] cycle_count;
		logic [31:0] elapsed_us;
		logic [63:0] absolute_us;
		logic [63:0] delta_us;
	} rsp_t;

endpackage

// ----- design/pdt_stream_if.sv -----
// Valid/ready channel carrying one payload per transaction.
interface pdt_stream_if #(
	parameter type payload_t = logic
) ();
	logic valid;
	logic ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- design/periodic_deadline_timer_top.sv -----
// Periodic deadline timer: grid anchoring, overrun count and microsecond reports.
//
// req (sink) takes one transaction per cycle request or restart; rsp (source)
// returns exactly one result transaction for each. Both are valid/ready.
// Registers are to be written over the APB port only while the block is
// idle; the block itself does not enforce this. A restart clears the period
// count and the grid anchor; its all-zero result passes through the finish
// state into the output register.
// A cycle request runs on a bit-serial restoring divider and a shift-add
// multiplier (one multiplier bit per cycle, stops at the top set bit). A
// request on the grid skips the period division and multiply. The first
// request after a restart or a rephase adds one division, plus with phase
// alignment a second division and a multiply.
// One request is processed at a time; a new one is taken once the previous
// result sits in the output register, so a stalled receiver holds at most
// one finished result plus one in the finish state.
// Reset (arst_n low) loads the register defaults, clears the anchor, count,
// previous microseconds and last rephase value, and empties the output.
module periodic_deadline_timer_top (
	input  logic clk,
	input  logic arst_n,
	pdt_stream_if.sink req,
	pdt_stream_if.source rsp,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [pdt_pkg::AddrWidth-1:0] paddr,
	input  logic [pdt_pkg::DataWidth-1:0] pwdata,
	output logic [pdt_pkg::DataWidth-1:0] prdata,
	output logic pready
);
	import pdt_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIV_NOW,
		S_DIV_SEC,
		S_ALIGN,
		S_MUL_START,
		S_CMP,
		S_DIV_PER,
		S_MUL_K,
		S_DIV_ABS,
		S_DELTA,
		S_MUL_EL,
		S_FINISH
	} state_t;

	// configuration registers
	logic [47:0] ticks_per_period_q;
	logic [31:0] period_us_q;
	logic [15:0] ticks_per_us_q;
	logic [19:0] phase_us_q;

	// run state
	state_t state_q;
	logic [63:0] now_q;
	logic [7:0] reph_q;
	logic align_q;
	logic [63:0] start_q;
	logic started_q;
	logic [31:0] periods_q;
	logic [63:0] prev_q;
	logic [7:0] last_reph_q;
	logic [19:0] phase_now_q;
	logic [63:0] k_q;
	logic [31:0] el_w_q;
	logic [63:0] abs_w_q;
	logic [63:0] delta_w_q;

	// shared divider and multiplier
	logic [63:0] dvd_q;
	logic [47:0] dvs_q;
	logic [47:0] rem_q;
	logic [5:0] cnt_q;
	logic [63:0] mcd_q;
	logic [47:0] mpl_q;
	logic [63:0] acc_q;

	logic rsp_valid_q;
	rsp_t rsp_q;

	logic cfg_wr;
	logic [47:0] tpu_eff;
	logic [47:0] per_eff;
	logic [48:0] div_trial;
	logic div_ge;
	logic [47:0] div_rem_next;
	logic [63:0] div_quot_next;
	logic div_last;
	logic [63:0] mul_acc_next;
	logic mul_last;
	logic [63:0] align_us;
	logic [63:0] gap_m1;
	logic start_lt;
	logic slot_free;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_per_period_q <= TicksPerPeriodReset;
			period_us_q <= PeriodUsReset;
			ticks_per_us_q <= TicksPerUsReset;
			phase_us_q <= PhaseUsReset;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[4:3]))
				REG_TICKS_PER_PERIOD: ticks_per_period_q <= pwdata[47:0];
				REG_PERIOD_US: period_us_q <= pwdata[31:0];
				REG_TICKS_PER_US: ticks_per_us_q <= pwdata[15:0];
				REG_PHASE_US: phase_us_q <= pwdata[19:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[4:3]))
			REG_TICKS_PER_PERIOD: prdata = {16'd0, ticks_per_period_q};
			REG_PERIOD_US: prdata = {32'd0, period_us_q};
			REG_TICKS_PER_US: prdata = {48'd0, ticks_per_us_q};
			REG_PHASE_US: prdata = {44'd0, phase_us_q};
			default: prdata = '0;
		endcase
	end

	// zero divisors count as one
	assign tpu_eff = (ticks_per_us_q == 16'd0) ? 48'd1 : {32'd0, ticks_per_us_q};
	assign per_eff = (ticks_per_period_q == 48'd0) ? 48'd1 : ticks_per_period_q;

	// restoring division, one quotient bit per cycle
	assign div_trial = {rem_q, dvd_q[63]};
	assign div_ge = div_trial >= {1'b0, dvs_q};
	assign div_rem_next = div_ge ? 48'(div_trial - {1'b0, dvs_q}) : div_trial[47:0];
	assign div_quot_next = {dvd_q[62:0], div_ge};
	assign div_last = cnt_q == 6'd63;

	// shift-add multiply, low 64 bits, one multiplier bit per cycle
	assign mul_acc_next = mpl_q[0] ? acc_q + mcd_q : acc_q;
	assign mul_last = mpl_q[47:1] == 47'd0;

	assign align_us = prev_q + {44'd0, phase_now_q} - {44'd0, rem_q[19:0]};
	assign gap_m1 = now_q - start_q - 64'd1;
	assign start_lt = start_q < now_q;
	assign slot_free = !rsp_valid_q || rsp.ready;

	assign req.ready = state_q == S_IDLE;
	assign rsp.valid = rsp_valid_q;
	assign rsp.payload = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			now_q <= '0;
			reph_q <= '0;
			align_q <= 1'b0;
			start_q <= '0;
			started_q <= 1'b0;
			periods_q <= '0;
			prev_q <= '0;
			last_reph_q <= '0;
			phase_now_q <= MicrosPerSecond;
			k_q <= '0;
			el_w_q <= '0;
			abs_w_q <= '0;
			delta_w_q <= '0;
			dvd_q <= '0;
			dvs_q <= '0;
			rem_q <= '0;
			cnt_q <= '0;
			mcd_q <= '0;
			mpl_q <= '0;
			acc_q <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q <= '0;
		end else begin
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						now_q <= req.payload.now_ticks;
						reph_q <= req.payload.rephase_value;
						if (op_t'(req.payload.operation) == OP_RESTART) begin
							periods_q <= '0;
							start_q <= '0;
							started_q <= 1'b0;
							phase_now_q <= phase_us_q;
							el_w_q <= '0;
							abs_w_q <= '0;
							delta_w_q <= '0;
							state_q <= S_FINISH;
						end else if (req.payload.rephase_value > last_reph_q || !started_q) begin
							align_q <= !(req.payload.rephase_value > last_reph_q) &&
								(phase_now_q < MicrosPerSecond);
							start_q <= req.payload.now_ticks;
							started_q <= 1'b1;
							dvd_q <= req.payload.now_ticks;
							dvs_q <= tpu_eff;
							rem_q <= '0;
							cnt_q <= '0;
							state_q <= S_DIV_NOW;
						end else begin
							state_q <= S_CMP;
						end
					end
				end
				S_DIV_NOW: begin
					dvd_q <= div_quot_next;
					rem_q <= div_rem_next;
					cnt_q <= cnt_q + 6'd1;
					if (div_last) begin
						prev_q <= div_quot_next;
						if (align_q) begin
							dvs_q <= {28'd0, MicrosPerSecond};
							rem_q <= '0;
							cnt_q <= '0;
							state_q <= S_DIV_SEC;
						end else begin
							state_q <= S_CMP;
						end
					end
				end
				S_DIV_SEC: begin
					dvd_q <= div_quot_next;
					rem_q <= div_rem_next;
					cnt_q <= cnt_q + 6'd1;
					if (div_last) begin
						state_q <= S_ALIGN;
					end
				end
				S_ALIGN: begin
					prev_q <= align_us;
					mcd_q <= align_us;
					mpl_q <= tpu_eff;
					acc_q <= '0;
					state_q <= S_MUL_START;
				end
				S_MUL_START: begin
					acc_q <= mul_acc_next;
					mcd_q <= {mcd_q[62:0], 1'b0};
					mpl_q <= {1'b0, mpl_q[47:1]};
					if (mul_last) begin
						start_q <= mul_acc_next;
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					rem_q <= '0;
					cnt_q <= '0;
					if (start_lt) begin
						dvd_q <= gap_m1;
						dvs_q <= per_eff;
						state_q <= S_DIV_PER;
					end else begin
						k_q <= '0;
						dvd_q <= start_q;
						dvs_q <= tpu_eff;
						state_q <= S_DIV_ABS;
					end
				end
				S_DIV_PER: begin
					dvd_q <= div_quot_next;
					rem_q <= div_rem_next;
					cnt_q <= cnt_q + 6'd1;
					if (div_last) begin
						k_q <= div_quot_next + 64'd1;
						mcd_q <= div_quot_next + 64'd1;
						mpl_q <= per_eff;
						acc_q <= start_q;
						state_q <= S_MUL_K;
					end
				end
				S_MUL_K: begin
					acc_q <= mul_acc_next;
					mcd_q <= {mcd_q[62:0], 1'b0};
					mpl_q <= {1'b0, mpl_q[47:1]};
					if (mul_last) begin
						start_q <= mul_acc_next;
						periods_q <= periods_q + k_q[31:0];
						dvd_q <= mul_acc_next;
						dvs_q <= tpu_eff;
						rem_q <= '0;
						cnt_q <= '0;
						state_q <= S_DIV_ABS;
					end
				end
				S_DIV_ABS: begin
					dvd_q <= div_quot_next;
					rem_q <= div_rem_next;
					cnt_q <= cnt_q + 6'd1;
					if (div_last) begin
						state_q <= S_DELTA;
					end
				end
				S_DELTA: begin
					abs_w_q <= dvd_q;
					delta_w_q <= dvd_q - prev_q;
					prev_q <= dvd_q;
					last_reph_q <= reph_q;
					mcd_q <= {32'd0, periods_q};
					mpl_q <= {16'd0, period_us_q};
					acc_q <= '0;
					state_q <= S_MUL_EL;
				end
				S_MUL_EL: begin
					acc_q <= mul_acc_next;
					mcd_q <= {mcd_q[62:0], 1'b0};
					mpl_q <= {1'b0, mpl_q[47:1]};
					if (mul_last) begin
						el_w_q <= mul_acc_next[31:0];
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (slot_free) begin
						rsp_q.deadline_ticks <= start_q;
						rsp_q.cycle_count <= periods_q;
						rsp_q.elapsed_us <= el_w_q;
						rsp_q.absolute_us <= abs_w_q;
						rsp_q.delta_us <= delta_w_q;
						rsp_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> state_q != S_IDLE)
		else $error("accepted transaction left block idle");

	a_grid_anchored: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CMP |-> started_q)
		else $error("deadline search without an anchored grid");

	a_skip_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MUL_K |-> k_q != 64'd0)
		else $error("overrun multiply with zero period count");

	a_finish_publishes: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FINISH && slot_free |=> rsp_valid_q && state_q == S_IDLE)
		else $error("finished result not published");

endmodule
